@@ hdl/pstrm_pkg.sv @@
// ----------------------------------------------------------------------------
// pstrm_pkg
// Types and constants shared by the per-stream transfer rate monitor.
// ----------------------------------------------------------------------------
package pstrm_pkg;

  localparam int IDX_W   = 8;
  localparam int TIME_W  = 32;
  localparam int BYTES_W = 48;
  localparam int RATE_W  = 49;
  localparam int ELAP_W  = 33;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] STAT_UPDATED    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_IDX_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_COUNT_HIGH = 2'd2;

  typedef struct packed {
    logic        [TIME_W-1:0]  first_time;
    logic        [TIME_W-1:0]  last_time;
    logic        [BYTES_W-1:0] bytes;
    logic signed [RATE_W-1:0]  avg;
    logic signed [RATE_W-1:0]  inst;
  } entry_t;

endpackage

@@ hdl/pstrm_if.sv @@
// ----------------------------------------------------------------------------
// pstrm_if
// Report and result channels of the per-stream transfer rate monitor.
// ----------------------------------------------------------------------------
interface pstrm_report_if import pstrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   stream_index;
  logic [IDX_W-1:0]   stream_count;
  logic [TIME_W-1:0]  report_time;
  logic [BYTES_W-1:0] bytes_done;

  modport source (output valid, stream_index, stream_count, report_time, bytes_done,
                  input ready);
  modport sink (input valid, stream_index, stream_count, report_time, bytes_done,
                output ready);
endinterface

interface pstrm_result_if import pstrm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0]  status;
  logic signed [RATE_W-1:0]  stream_avg_rate;
  logic signed [RATE_W-1:0]  stream_instant_rate;
  logic        [BYTES_W-1:0] total_bytes;
  logic signed [RATE_W-1:0]  sum_avg_rate;
  logic signed [RATE_W-1:0]  sum_instant_rate;
  logic signed [ELAP_W-1:0]  overall_elapsed;

  modport source (output valid, status, stream_avg_rate, stream_instant_rate, total_bytes,
                  sum_avg_rate, sum_instant_rate, overall_elapsed,
                  input ready);
  modport sink (input valid, status, stream_avg_rate, stream_instant_rate, total_bytes,
                sum_avg_rate, sum_instant_rate, overall_elapsed,
                output ready);
endinterface

@@ hdl/per_stream_transfer_rate_monitor.sv @@
// an accepted report that updates an entry passes through the 49-step bit-serial division
// of both rates and then the one-read-per-cycle sum over the N active entries of the entry
// memory, N being the active stream count; an ignored report goes straight to the sum
// one report is in work at a time and the next can be taken in the cycle after the
// previous result is loaded
// reset clears all entries through per-entry valid bits, the active count and global times
// ----------------------------------------------------------------------------
// per_stream_transfer_rate_monitor
// Keeps per-stream times, bytes and rates in a memory and reports aggregates.
// ----------------------------------------------------------------------------
module per_stream_transfer_rate_monitor import pstrm_pkg::*; #(
  parameter int MAX_STREAMS = 16
) (
  input  logic             clk,
  input  logic             rst,
  pstrm_report_if.sink     report,
  pstrm_result_if.source   result
);

  localparam int AW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CNT_W = 9;
  localparam int SUM_W = RATE_W + CNT_W;
  localparam int TOT_W = BYTES_W + CNT_W;
  localparam int REM_W = ELAP_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STREAMS);
  localparam logic signed [SUM_W-1:0] S49_MAX = SUM_W'(64'sd281474976710655);
  localparam logic signed [SUM_W-1:0] S49_MIN = -SUM_W'(64'sd281474976710656);
  localparam logic [TOT_W-1:0] U48_MAX = TOT_W'(64'd281474976710655);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;

  entry_t mem [MAX_STREAMS];
  entry_t rd_data;
  logic   rd_vld;
  logic [AW-1:0] raddr;
  logic [MAX_STREAMS-1:0] vld;

  logic [IDX_W-1:0]   idx_r;
  logic [TIME_W-1:0]  t_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [CNT_W-1:0]   active_count;
  logic [TIME_W-1:0]  global_first;
  logic [TIME_W-1:0]  global_last;
  logic [STAT_W-1:0]  status_r;
  logic signed [RATE_W-1:0] avg_o;
  logic signed [RATE_W-1:0] inst_o;

  // entry being updated
  logic [TIME_W-1:0]        first_new;
  logic signed [RATE_W-1:0] old_avg;
  logic signed [RATE_W-1:0] old_inst;

  // two bit-serial dividers sharing one step counter
  logic [5:0]          div_cnt;
  logic [RATE_W-1:0]   dvd_a, dvd_b, q_a, q_b;
  logic [ELAP_W-1:0]   dsr_a, dsr_b;
  logic [REM_W-2:0]    rem_a, rem_b;
  logic                neg_a, neg_b, zero_a, zero_b;
  logic [REM_W-1:0]    trial_a, trial_b;
  logic                ge_a, ge_b;

  // sum pass
  logic [CNT_W-1:0]        sidx;
  logic                    pend;
  logic [TOT_W-1:0]        acc_tot;
  logic signed [SUM_W-1:0] acc_avg;
  logic signed [SUM_W-1:0] acc_inst;

  entry_t e_cur;
  logic signed [ELAP_W-1:0]  abs_el, diff_el;
  logic signed [RATE_W-1:0]  diff_sz;
  logic [TIME_W-1:0]         first_calc;
  logic signed [RATE_W-1:0]  avg_new, inst_new;

  always_comb begin
    e_cur = rd_vld ? rd_data : '0;
    first_calc = (e_cur.first_time == '0) ? t_r : e_cur.first_time;
    abs_el  = $signed({1'b0, t_r}) - $signed({1'b0, first_calc});
    diff_el = $signed({1'b0, t_r}) - $signed({1'b0, e_cur.last_time});
    diff_sz = $signed({1'b0, bytes_r}) - $signed({1'b0, e_cur.bytes});
    trial_a = {rem_a, dvd_a[RATE_W-1]};
    trial_b = {rem_b, dvd_b[RATE_W-1]};
    ge_a = trial_a >= {1'b0, dsr_a};
    ge_b = trial_b >= {1'b0, dsr_b};
    avg_new  = zero_a ? old_avg  : (neg_a ? -$signed(q_a) : $signed(q_a));
    inst_new = zero_b ? old_inst : (neg_b ? -$signed(q_b) : $signed(q_b));
    raddr = (state == S_SUM) ? sidx[AW-1:0] : report.stream_index[AW-1:0];
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[raddr];
    if (state == S_WR) begin
      mem[idx_r[AW-1:0]] <= '{first_time: first_new, last_time: t_r, bytes: bytes_r,
                              avg: avg_new, inst: inst_new};
    end
  end

  assign report.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vld          <= '0;
      rd_vld       <= 1'b0;
      active_count <= '0;
      global_first <= '0;
      global_last  <= '0;
      pend         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      rd_vld <= vld[raddr];
      if (result.valid && result.ready && state != S_DONE) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (report.valid) begin
            idx_r    <= report.stream_index;
            t_r      <= report.report_time;
            bytes_r  <= report.bytes_done;
            avg_o    <= '0;
            inst_o   <= '0;
            sidx     <= '0;
            pend     <= 1'b0;
            acc_tot  <= '0;
            acc_avg  <= '0;
            acc_inst <= '0;
            if ({1'b0, report.stream_count} > MAX_CNT) begin
              status_r <= STAT_COUNT_HIGH;
              state    <= S_SUM;
            end else begin
              if ({1'b0, report.stream_count} != active_count) begin
                for (int i = 0; i < MAX_STREAMS; i++) begin
                  if (CNT_W'(i) >= {1'b0, report.stream_count}) vld[i] <= 1'b0;
                end
                active_count <= {1'b0, report.stream_count};
              end
              if (report.stream_index >= report.stream_count) begin
                status_r <= STAT_IDX_RANGE;
                state    <= S_SUM;
              end else begin
                status_r <= STAT_UPDATED;
                state    <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          first_new <= first_calc;
          old_avg   <= e_cur.avg;
          old_inst  <= e_cur.inst;
          dvd_a  <= {1'b0, bytes_r};
          dsr_a  <= abs_el[ELAP_W-1] ? ELAP_W'(-abs_el) : ELAP_W'(abs_el);
          neg_a  <= abs_el[ELAP_W-1];
          zero_a <= (abs_el == '0);
          dvd_b  <= diff_sz[RATE_W-1] ? RATE_W'(-diff_sz) : RATE_W'(diff_sz);
          dsr_b  <= diff_el[ELAP_W-1] ? ELAP_W'(-diff_el) : ELAP_W'(diff_el);
          neg_b  <= diff_sz[RATE_W-1] ^ diff_el[ELAP_W-1];
          zero_b <= (diff_el == '0);
          rem_a  <= '0;
          rem_b  <= '0;
          q_a    <= '0;
          q_b    <= '0;
          div_cnt <= '0;
          state  <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          rem_a <= ge_a ? (REM_W-1)'(trial_a - {1'b0, dsr_a}) : trial_a[REM_W-2:0];
          rem_b <= ge_b ? (REM_W-1)'(trial_b - {1'b0, dsr_b}) : trial_b[REM_W-2:0];
          q_a   <= {q_a[RATE_W-2:0], ge_a};
          q_b   <= {q_b[RATE_W-2:0], ge_b};
          dvd_a <= {dvd_a[RATE_W-2:0], 1'b0};
          dvd_b <= {dvd_b[RATE_W-2:0], 1'b0};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(RATE_W - 1)) state <= S_WR;
        end
        S_WR: begin
          vld[idx_r[AW-1:0]] <= 1'b1;
          avg_o  <= avg_new;
          inst_o <= inst_new;
          if (global_first == '0 || global_first < first_new) global_first <= first_new;
          if (global_last < t_r) global_last <= t_r;
          state <= S_SUM;
        end
        S_SUM: begin
          if (sidx < active_count) begin
            pend <= 1'b1;
            sidx <= sidx + CNT_W'(1);
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            acc_tot  <= acc_tot + {{CNT_W{1'b0}}, e_cur.bytes};
            acc_avg  <= acc_avg + {{CNT_W{e_cur.avg[RATE_W-1]}}, e_cur.avg};
            acc_inst <= acc_inst + {{CNT_W{e_cur.inst[RATE_W-1]}}, e_cur.inst};
          end
          if (sidx >= active_count && !pend) state <= S_DONE;
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload loads together with valid
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!result.valid || result.ready)) begin
      result.status              <= status_r;
      result.stream_avg_rate     <= avg_o;
      result.stream_instant_rate <= inst_o;
      result.total_bytes <= (acc_tot > U48_MAX) ? BYTES_W'(U48_MAX) : acc_tot[BYTES_W-1:0];
      result.sum_avg_rate <= (acc_avg > S49_MAX) ? RATE_W'(S49_MAX) :
                             (acc_avg < S49_MIN) ? RATE_W'(S49_MIN) : acc_avg[RATE_W-1:0];
      result.sum_instant_rate <= (acc_inst > S49_MAX) ? RATE_W'(S49_MAX) :
                                 (acc_inst < S49_MIN) ? RATE_W'(S49_MIN) :
                                 acc_inst[RATE_W-1:0];
      result.overall_elapsed <= $signed({1'b0, global_last}) - $signed({1'b0, global_first});
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives progress reports into the per-stream transfer rate monitor, predicts
// each result from its own copy of the stream table and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pstrm_pkg::*;

  localparam int NUM_STREAMS  = 16;
  localparam int RANDOM_ITEMS = 1630;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 600;
  localparam longint RATE_MAX = 64'sh0000_FFFF_FFFF_FFFF;
  localparam longint RATE_MIN = -64'sh0001_0000_0000_0000;

  typedef struct {
    logic        [1:0]        status;
    logic signed [RATE_W-1:0] avg;
    logic signed [RATE_W-1:0] inst;
    logic        [BYTES_W-1:0] total;
    logic signed [RATE_W-1:0] sum_avg;
    logic signed [RATE_W-1:0] sum_inst;
    logic signed [ELAP_W-1:0] elapsed;
  } outcome_t;

  typedef struct {
    logic [7:0]         idx;
    logic [7:0]         cnt;
    logic [TIME_W-1:0]  t;
    logic [BYTES_W-1:0] bytes;
    bit                 typed;
    logic [1:0]         status;
  } report_row_t;

  logic clk;
  logic rst;

  pstrm_report_if report ();
  pstrm_result_if result ();

  per_stream_transfer_rate_monitor #(.MAX_STREAMS(NUM_STREAMS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .report (report),
    .result (result)
  );

  // shadow stream table
  logic [TIME_W-1:0]  shd_first [NUM_STREAMS];
  logic [TIME_W-1:0]  shd_last  [NUM_STREAMS];
  logic [BYTES_W-1:0] shd_bytes [NUM_STREAMS];
  longint             shd_avg   [NUM_STREAMS];
  longint             shd_inst  [NUM_STREAMS];
  int unsigned        shd_active;
  logic [TIME_W-1:0]  shd_gfirst;
  logic [TIME_W-1:0]  shd_glast;

  outcome_t pending_results[$];
  int       mismatches;
  int       idle_cycles;
  int       sent;
  bit       hold_request;
  bit       sender_done;

  function automatic longint clamp_rate(longint v);
    if (v > RATE_MAX) return RATE_MAX;
    if (v < RATE_MIN) return RATE_MIN;
    return v;
  endfunction

  function automatic outcome_t track_report(logic [7:0] idx, logic [7:0] cnt,
                                            logic [TIME_W-1:0] t, logic [BYTES_W-1:0] b);
    outcome_t o;
    longint   abs_el, diff_el, diff_sz, tot, savg, sinst;
    int       k;
    o.status = STAT_UPDATED;
    o.avg = '0;
    o.inst = '0;
    tot = 0;
    savg = 0;
    sinst = 0;
    if (cnt > NUM_STREAMS) begin
      o.status = STAT_COUNT_HIGH;
    end else begin
      if (cnt != shd_active) begin
        for (k = cnt; k < NUM_STREAMS; k++) begin
          shd_first[k] = '0;
          shd_last[k]  = '0;
          shd_bytes[k] = '0;
          shd_avg[k]   = 0;
          shd_inst[k]  = 0;
        end
        shd_active = cnt;
      end
      if (idx >= cnt) begin
        o.status = STAT_IDX_RANGE;
      end else begin
        if (shd_first[idx] == 0) shd_first[idx] = t;
        abs_el  = longint'(t) - longint'(shd_first[idx]);
        diff_el = longint'(t) - longint'(shd_last[idx]);
        diff_sz = longint'(b) - longint'(shd_bytes[idx]);
        shd_last[idx]  = t;
        shd_bytes[idx] = b;
        if (abs_el != 0) shd_avg[idx] = clamp_rate(longint'(b) / abs_el);
        if (diff_el != 0) shd_inst[idx] = clamp_rate(diff_sz / diff_el);
        if (shd_gfirst == 0 || shd_gfirst < shd_first[idx]) shd_gfirst = shd_first[idx];
        if (shd_glast < t) shd_glast = t;
        o.avg  = RATE_W'(shd_avg[idx]);
        o.inst = RATE_W'(shd_inst[idx]);
      end
    end
    for (k = 0; k < shd_active && k < NUM_STREAMS; k++) begin
      tot   += longint'(shd_bytes[k]);
      savg  += shd_avg[k];
      sinst += shd_inst[k];
    end
    o.total    = (tot > 64'h0000_FFFF_FFFF_FFFF) ? '1 : tot[BYTES_W-1:0];
    o.sum_avg  = RATE_W'(clamp_rate(savg));
    o.sum_inst = RATE_W'(clamp_rate(sinst));
    o.elapsed  = ELAP_W'(longint'(shd_glast) - longint'(shd_gfirst));
    return o;
  endfunction

  // directed reports; status typed in where it is obvious
  report_row_t directed [23] = '{
    '{8'd0,   8'd0,   32'd0,          48'd0,            1'b1, STAT_IDX_RANGE},
    '{8'd0,   8'd17,  32'd5,          48'd5,            1'b1, STAT_COUNT_HIGH},
    '{8'd255, 8'd255, 32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF, 1'b1, STAT_COUNT_HIGH},
    '{8'd255, 8'd16,  32'd10,         48'd1,            1'b1, STAT_IDX_RANGE},
    '{8'd16,  8'd16,  32'd10,         48'd1,            1'b1, STAT_IDX_RANGE},
    '{8'd0,   8'd16,  32'd0,          48'd100,          1'b1, STAT_UPDATED},
    '{8'd0,   8'd16,  32'd100,        48'd1000,         1'b1, STAT_UPDATED},
    '{8'd0,   8'd16,  32'd100,        48'd2000,         1'b0, STAT_UPDATED},
    '{8'd0,   8'd16,  32'd50,         48'd500,          1'b0, STAT_UPDATED},
    '{8'd15,  8'd16,  32'hFFFF_FFFF,  48'hFFFF_FFFF_FFFF, 1'b0, STAT_UPDATED},
    '{8'd15,  8'd16,  32'd1,          48'd0,            1'b0, STAT_UPDATED},
    '{8'd14,  8'd16,  32'd1,          48'hFFFF_FFFF_FFFF, 1'b0, STAT_UPDATED},
    '{8'd14,  8'd16,  32'd2,          48'hFFFF_FFFF_FFFF, 1'b0, STAT_UPDATED},
    '{8'd13,  8'd16,  32'd3,          48'h8000_0000_0000, 1'b0, STAT_UPDATED},
    '{8'd12,  8'd16,  32'd4,          48'hFFFF_FFFF_FFFF, 1'b0, STAT_UPDATED},
    '{8'd3,   8'd4,   32'd200,        48'd7,            1'b0, STAT_UPDATED},
    '{8'd12,  8'd4,   32'd200,        48'd7,            1'b1, STAT_IDX_RANGE},
    '{8'd0,   8'd1,   32'd300,        48'd9000,         1'b0, STAT_UPDATED},
    '{8'd0,   8'd1,   32'd300,        48'd1,            1'b0, STAT_UPDATED},
    '{8'd1,   8'd16,  32'h8000_0000,  48'h5555_5555_5555, 1'b0, STAT_UPDATED},
    '{8'd1,   8'd16,  32'h7FFF_FFFF,  48'hAAAA_AAAA_AAAA, 1'b0, STAT_UPDATED},
    '{8'd0,   8'd0,   32'd400,        48'd1,            1'b1, STAT_IDX_RANGE},
    '{8'd2,   8'd128, 32'd400,        48'd1,            1'b1, STAT_COUNT_HIGH}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random gap length: mostly none or short, a few long, with bursts
  bit gap_burst;
  function automatic int pick_gap();
    int r;
    if (gap_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer_report(logic [7:0] idx, logic [7:0] cnt, logic [TIME_W-1:0] t,
                              logic [BYTES_W-1:0] b, bit typed, logic [1:0] stat);
    outcome_t o;
    int       g;
    g = pick_gap();
    repeat (g) begin
      report.valid <= 1'b0;
      @(negedge clk);
    end
    report.valid        <= 1'b1;
    report.stream_index <= idx;
    report.stream_count <= cnt;
    report.report_time  <= t;
    report.bytes_done   <= b;
    do @(posedge clk); while (!report.ready);
    o = track_report(idx, cnt, t, b);
    if (typed) o.status = stat;
    pending_results.push_back(o);
    sent++;
    @(negedge clk);
  endtask

  // stimulus
  logic [TIME_W-1:0]  gen_time  [NUM_STREAMS];
  logic [BYTES_W-1:0] gen_bytes [NUM_STREAMS];

  initial begin
    int          n, k, r;
    int unsigned cur_cnt;
    logic [7:0]  idx, cnt;
    logic [TIME_W-1:0]  t;
    logic [BYTES_W-1:0] b;
    rst = 1'b1;
    report.valid = 1'b0;
    report.stream_index = '0;
    report.stream_count = '0;
    report.report_time = '0;
    report.bytes_done = '0;
    sent = 0;
    sender_done = 1'b0;
    hold_request = 1'b0;
    gap_burst = 1'b0;
    for (k = 0; k < NUM_STREAMS; k++) begin
      shd_first[k] = '0;
      shd_last[k] = '0;
      shd_bytes[k] = '0;
      shd_avg[k] = 0;
      shd_inst[k] = 0;
      gen_time[k] = $urandom_range(1, 1000);
      gen_bytes[k] = '0;
    end
    shd_active = 0;
    shd_gfirst = '0;
    shd_glast = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      offer_report(directed[i].idx, directed[i].cnt, directed[i].t, directed[i].bytes,
                   directed[i].typed, directed[i].status);

    cur_cnt = $urandom_range(1, NUM_STREAMS);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 4) gap_burst = ~gap_burst;
      if (n == 300) hold_request = 1'b1;
      if (n == 700) begin
        report.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 3) cur_cnt = $urandom_range(1, NUM_STREAMS);
      if (r < 15) begin
        // noise: any field value at all
        idx = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 17));
        cnt = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 17));
        t   = $urandom;
        b   = BYTES_W'({$urandom, $urandom});
      end else begin
        cnt = 8'(cur_cnt);
        idx = 8'($urandom_range(0, cur_cnt - 1));
        if ($urandom_range(0, 49) == 0) gen_time[idx] = $urandom;
        else gen_time[idx] = gen_time[idx] + $urandom_range(0, 20);
        if ($urandom_range(0, 19) == 0) gen_bytes[idx] = BYTES_W'({$urandom, $urandom});
        else gen_bytes[idx] = BYTES_W'(gen_bytes[idx] + $urandom_range(0, 1 << 22));
        t = gen_time[idx];
        b = gen_bytes[idx];
      end
      offer_report(idx, cnt, t, b, 1'b0, STAT_UPDATED);
    end
    report.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // result side: random backpressure plus one long hold-off
  initial begin
    int g;
    int hold_left;
    bit hold_done;
    result.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (!result.ready) begin
        result.ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          result.ready <= 1'b0;
          hold_left = g - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && result.valid && result.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (result.status !== e.status || result.stream_avg_rate !== e.avg ||
            result.stream_instant_rate !== e.inst || result.total_bytes !== e.total ||
            result.sum_avg_rate !== e.sum_avg || result.sum_instant_rate !== e.sum_inst ||
            result.overall_elapsed !== e.elapsed) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  exp st=%0d avg=%0d inst=%0d tot=%0d savg=%0d sinst=%0d el=%0d",
                     e.status, e.avg, e.inst, e.total, e.sum_avg, e.sum_inst, e.elapsed);
            $display("  got st=%0d avg=%0d inst=%0d tot=%0d savg=%0d sinst=%0d el=%0d",
                     result.status, result.stream_avg_rate, result.stream_instant_rate,
                     result.total_bytes, result.sum_avg_rate, result.sum_instant_rate,
                     result.overall_elapsed);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (report.valid && report.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    fork
      begin
        wait (sender_done && pending_results.size() == 0);
        repeat (100) @(posedge clk);
      end
      wait (idle_cycles >= IDLE_LIMIT);
    join_any
    if (idle_cycles < IDLE_LIMIT && mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (idle_cycles >= IDLE_LIMIT) $display("timeout, %0d results outstanding",
                                              pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
